/* src/integer_list_sorter_unit_defines.svh */
// Assertion macros used by the sorter RTL.
`ifndef INTEGER_LIST_SORTER_UNIT_DEFINES_SVH
`define INTEGER_LIST_SORTER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// Checked only while the block is out of reset.
`define ILS_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// Checked at every edge, reset included.
`define ILS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ILS_ASSERT(lbl, clk, rstn, prop, msg)
`define ILS_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

/* src/ils_pkg.sv */
package ils_pkg;

    // Number of values one batch may hold.
    localparam int MaxItems = 64;
    // Width of the fill counter; it must hold MaxItems itself.
    localparam int CntW = $clog2(MaxItems + 1);

    typedef logic signed [31:0] word_t;
    typedef logic [CntW-1:0] count_t;

    typedef enum logic {
        ST_LOAD,
        ST_DRAIN
    } state_t;

    // Command broadcast to every cell of the row.
    typedef struct packed {
        logic  insert;
        logic  pop;
        word_t value;
    } cell_ctl_t;

endpackage

/* src/ils_cell.sv */
module ils_cell (
    input  logic              aclk,
    input  logic              aresetn,
    input  ils_pkg::cell_ctl_t ctl,
    input  logic              left_gt,
    input  ils_pkg::word_t    left_value,
    input  logic              left_valid,
    input  ils_pkg::word_t    right_value,
    input  logic              right_valid,
    output logic              gt,
    output ils_pkg::word_t    value,
    output logic              valid
);
    import ils_pkg::*;

    word_t value_reg, value_next;
    logic  valid_reg, valid_next;

    // An empty cell counts as holding plus infinity.
    assign gt = !valid_reg || (value_reg > ctl.value);

    always_comb begin
        value_next = value_reg;
        valid_next = valid_reg;
        if (ctl.insert && gt) begin
            if (left_gt) begin
                value_next = left_value;
                valid_next = left_valid;
            end else begin
                value_next = ctl.value;
                valid_next = 1'b1;
            end
        end else if (ctl.pop) begin
            value_next = right_value;
            valid_next = right_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        value_reg <= value_next;
    end

    assign value = value_reg;
    assign valid = valid_reg;

endmodule

/* src/ils_chain.sv */
module ils_chain (
    input  logic               aclk,
    input  logic               aresetn,
    input  ils_pkg::cell_ctl_t ctl,
    output ils_pkg::word_t     head_value,
    output logic               head_valid
);
    import ils_pkg::*;

    logic  gt_w    [MaxItems];
    word_t value_w [MaxItems];
    logic  valid_w [MaxItems];

    for (genvar i = 0; i < MaxItems; i++) begin : g_cell
        logic  l_gt, r_valid, l_valid;
        word_t l_value, r_value;

        if (i == 0) begin : g_first
            assign l_gt    = 1'b0;
            assign l_value = '0;
            assign l_valid = 1'b0;
        end else begin : g_mid
            assign l_gt    = gt_w[i-1];
            assign l_value = value_w[i-1];
            assign l_valid = valid_w[i-1];
        end

        if (i == MaxItems - 1) begin : g_tail
            assign r_value = '0;
            assign r_valid = 1'b0;
        end else begin : g_body
            assign r_value = value_w[i+1];
            assign r_valid = valid_w[i+1];
        end

        ils_cell u_cell (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .ctl         (ctl),
            .left_gt     (l_gt),
            .left_value  (l_value),
            .left_valid  (l_valid),
            .right_value (r_value),
            .right_valid (r_valid),
            .gt          (gt_w[i]),
            .value       (value_w[i]),
            .valid       (valid_w[i])
        );
    end

    assign head_value = value_w[0];
    assign head_valid = valid_w[0];

endmodule

/* src/integer_list_sorter_unit.sv */
// Batch sorter for signed 32-bit integers.
// The slave channel takes one value per request; s_tlast marks the last value of a batch.
// While loading, every request is taken as soon as it arrives: the value is broadcast to a
// row of 64 cells, each cell compares it with its own value, and the row opens a gap at the
// right place by shifting the larger values one cell to the right.
// Values beyond 64 in one batch are dropped and the batch is flagged as overflowed.
// In the cycle after the last request the master channel starts to present the batch in
// ascending order straight from the head cell, one result per cycle while m_tready is
// high; m_tlast marks the final result and m_tuser is the overflow flag of the batch.
// Every accepted result shifts the whole row one cell toward the head.
// No new batch is taken while results are being drained.
// When the receiver stalls, the head cell and the fill counter hold unchanged.
// Reset (aresetn low at a clock edge) empties the row, clears the counters and the
// overflow flag, and leaves the block ready to load.
`include "integer_list_sorter_unit_defines.svh"

module integer_list_sorter_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] value
    input  logic        s_tlast,   // last
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] value_res
    output logic        m_tlast,   // last_res
    output logic        m_tuser    // [0] overflowed
);
    import ils_pkg::*;

    localparam count_t CntMax = count_t'(MaxItems);
    localparam count_t CntOne = count_t'(1);

    state_t    state_reg, state_next;
    count_t    count_reg, count_next;
    logic      ovf_reg, ovf_next;
    cell_ctl_t ctl;
    word_t     head_value;
    logic      head_valid;
    logic      s_fire, m_fire, full;

    assign s_fire = s_tvalid && s_tready;
    assign m_fire = m_tvalid && m_tready;
    assign full   = (count_reg == CntMax);

    // Next state: a batch closes on its last request and reopens after the last result.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_LOAD: begin
                if (s_fire && s_tlast) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (m_fire && (count_reg == CntOne)) begin
                    state_next = ST_LOAD;
                end
            end
            default: state_next = ST_LOAD;
        endcase
    end

    // Counter and overflow flag. The count tracks filled cells in both phases.
    always_comb begin
        count_next = count_reg;
        ovf_next   = ovf_reg;
        if (s_fire) begin
            if (full) begin
                ovf_next = 1'b1;
            end else begin
                count_next = count_reg + CntOne;
            end
        end
        if (m_fire) begin
            count_next = count_reg - CntOne;
            if (count_reg == CntOne) begin
                ovf_next = 1'b0;
            end
        end
    end

    // Outputs and row commands.
    always_comb begin
        s_tready   = 1'b0;
        m_tvalid   = 1'b0;
        ctl.insert = 1'b0;
        ctl.pop    = 1'b0;
        ctl.value  = word_t'(s_tdata);
        case (state_reg)
            ST_LOAD: begin
                s_tready   = 1'b1;
                ctl.insert = s_tvalid && !full;
            end
            ST_DRAIN: begin
                m_tvalid = 1'b1;
                ctl.pop  = m_tready;
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_LOAD;
            count_reg <= '0;
            ovf_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
        end
    end

    ils_chain u_chain (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctl        (ctl),
        .head_value (head_value),
        .head_valid (head_valid)
    );

    assign m_tdata = head_value;
    assign m_tlast = (count_reg == CntOne);
    assign m_tuser = ovf_reg;

    // The head cell must hold a value whenever a result is offered.
    `ILS_ASSERT(a_head_valid, aclk, aresetn, m_tvalid |-> head_valid, "result offered from empty row")
    // The fill count never passes the row length; while reset is held it is not yet defined.
    `ILS_ASSERT_ALWAYS(a_count_range, aclk, !aresetn || (count_reg <= CntMax), "fill count beyond capacity")
    // Draining never starts or runs with an empty batch.
    `ILS_ASSERT(a_drain_nonempty, aclk, aresetn, (state_reg == ST_DRAIN) |-> (count_reg != '0), "drain with no values")
    // After the final result the block is empty and ready for a new batch.
    `ILS_ASSERT(a_batch_end, aclk, aresetn, (m_fire && m_tlast) |=> (!head_valid && count_reg == '0 && !ovf_reg), "row not empty after final result")

endmodule
